// File: design/sync_frame_deframer_fletcher_assert.svh
`ifndef SYNC_FRAME_DEFRAMER_FLETCHER_ASSERT_SVH
`define SYNC_FRAME_DEFRAMER_FLETCHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SFDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SFDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sfdf_pkg.sv
package sfdf_pkg;

  localparam int FRAME_LEN = 14;
  localparam int BYTE_W    = 8;
  localparam int AXIS_W    = 16;
  localparam int ADDR_W    = $clog2(FRAME_LEN);
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

  localparam logic [ADDR_W-1:0] POS_SYNC_A    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] POS_SYNC_B    = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] POS_SUM_FIRST = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] POS_X_HI      = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] POS_X_LO      = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] POS_Y_HI      = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] POS_Y_LO      = ADDR_W'(9);
  localparam logic [ADDR_W-1:0] POS_Z_HI      = ADDR_W'(10);
  localparam logic [ADDR_W-1:0] POS_SUM_LAST  = ADDR_W'(11);
  localparam logic [ADDR_W-1:0] POS_CK_A      = ADDR_W'(12);
  localparam logic [ADDR_W-1:0] POS_CK_B      = ADDR_W'(13);

  typedef struct packed {
    logic              clr;
    logic              vld;
    logic [ADDR_W-1:0] tag;
  } sum_ctl_t;

endpackage

// File: design/sync_frame_deframer_fletcher.sv
// Byte-stream deframer for 14-byte frames that start with the sync pair 0xB5 0x62 and
// end with an 8-bit Fletcher pair over bytes 2 to 11. A good frame yields one beat with
// three signed big-endian axis values; a bad header or checksum drops bytes up to the
// next held 0xB5 and yields nothing. The frame lives in a 14-byte memory with one
// registered read port, and every pass walks it one entry a cycle: an ordinary byte
// takes an accept plus a two-entry header read, the last byte of a frame adds a
// checksum pass and a hand-over of the result once the output register is free, and a
// resync adds a scan and a copy. A finished result waits in an output register while
// new bytes are taken; only the next finished frame waits for it to drain.
module sync_frame_deframer_fletcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // axis_x[15:0], axis_y[31:16], axis_z[47:32]
);
  import sfdf_pkg::*;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  sum_ctl_t          sum_ctl;
  logic              match;
  logic              emit;
  logic              out_busy;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;

  sfdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sfdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata),
    .sum_ctl  (sum_ctl),
    .match    (match),
    .out_busy (out_busy),
    .emit     (emit)
  );

  sfdf_fletcher u_fletcher (
    .clk    (clk),
    .ctl    (sum_ctl),
    .rdata  (rdata),
    .match  (match),
    .axis_x (axis_x),
    .axis_y (axis_y),
    .axis_z (axis_z)
  );

  assign out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      m_tdata <= {axis_z, axis_y, axis_x};
    end
  end

endmodule

// File: design/sfdf_ram.sv
module sfdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sfdf_fletcher.sv
module sfdf_fletcher (
  input  logic                         clk,
  input  sfdf_pkg::sum_ctl_t           ctl,
  input  logic [sfdf_pkg::BYTE_W-1:0]  rdata,
  output logic                         match,
  output logic signed [sfdf_pkg::AXIS_W-1:0] axis_x,
  output logic signed [sfdf_pkg::AXIS_W-1:0] axis_y,
  output logic signed [sfdf_pkg::AXIS_W-1:0] axis_z
);
  import sfdf_pkg::*;

  logic [BYTE_W-1:0] sum_a;
  logic [BYTE_W-1:0] sum_b;
  logic [BYTE_W-1:0] a_add;
  logic              ok_a;
  logic              ok_b;
  logic              in_span;

  assign a_add   = sum_a + rdata;
  assign in_span = (ctl.tag >= POS_SUM_FIRST) && (ctl.tag <= POS_SUM_LAST);
  assign match   = ok_a && ok_b;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (ctl.vld && in_span) begin
      sum_a <= a_add;
      sum_b <= sum_b + a_add;
    end
    if (ctl.vld) begin
      case (ctl.tag)
        POS_X_HI:     axis_x[15:8] <= rdata;
        POS_X_LO:     axis_x[7:0]  <= rdata;
        POS_Y_HI:     axis_y[15:8] <= rdata;
        POS_Y_LO:     axis_y[7:0]  <= rdata;
        POS_Z_HI:     axis_z[15:8] <= rdata;
        POS_SUM_LAST: axis_z[7:0]  <= rdata;
        POS_CK_A:     ok_a <= (rdata == sum_a);
        POS_CK_B:     ok_b <= (rdata == sum_b);
        default: ;
      endcase
    end
  end

endmodule

// File: design/sfdf_ctrl.sv
`include "sync_frame_deframer_fletcher_assert.svh"

module sfdf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sfdf_pkg::BYTE_W-1:0] in_byte,
  output logic                        in_ready,
  output logic                        we,
  output logic [sfdf_pkg::ADDR_W-1:0] waddr,
  output logic [sfdf_pkg::BYTE_W-1:0] wdata,
  output logic [sfdf_pkg::ADDR_W-1:0] raddr,
  input  logic [sfdf_pkg::BYTE_W-1:0] rdata,
  output sfdf_pkg::sum_ctl_t          sum_ctl,
  input  logic                        match,
  input  logic                        out_busy,
  output logic                        emit
);
  import sfdf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HDR0 = 8'b0000_0010,
    S_HDR1 = 8'b0000_0100,
    S_HDR2 = 8'b0000_1000,
    S_SCAN = 8'b0001_0000,
    S_COPY = 8'b0010_0000,
    S_SUM  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [ADDR_W-1:0] k, k_next;
  logic [BYTE_W-1:0] b0, b0_next;
  logic [ADDR_W-1:0] tag;
  logic              tag_vld;
  logic              iss;
  logic              clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      tag_vld <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      tag_vld <= iss;
    end
    ptr <= ptr_next;
    k   <= k_next;
    b0  <= b0_next;
    tag <= raddr;
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    ptr_next   = ptr;
    k_next     = k;
    b0_next    = b0;
    iss        = 1'b0;
    raddr      = POS_SYNC_A;
    we         = 1'b0;
    waddr      = fill[ADDR_W-1:0];
    wdata      = in_byte;
    in_ready   = 1'b0;
    emit       = 1'b0;
    clr        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          we         = 1'b1;
          fill_next  = fill + 1'b1;
          state_next = S_HDR0;
        end
      end
      S_HDR0: begin
        iss        = 1'b1;
        raddr      = POS_SYNC_A;
        state_next = S_HDR1;
      end
      S_HDR1: begin
        iss        = 1'b1;
        raddr      = POS_SYNC_B;
        b0_next    = rdata;
        state_next = S_HDR2;
      end
      S_HDR2: begin
        if (b0 != SYNC_FIRST || (fill >= CNT_W'(2) && rdata != SYNC_SECOND)) begin
          ptr_next   = CNT_W'(POS_SYNC_B);
          state_next = S_SCAN;
        end else if (fill == CNT_W'(FRAME_LEN)) begin
          ptr_next   = CNT_W'(POS_SUM_FIRST);
          clr        = 1'b1;
          state_next = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (tag_vld && rdata == SYNC_FIRST) begin
          k_next     = tag;
          ptr_next   = CNT_W'(tag);
          state_next = S_COPY;
        end else if (ptr >= fill && !tag_vld) begin
          fill_next  = '0;
          state_next = S_IDLE;
        end else if (ptr < fill) begin
          iss      = 1'b1;
          raddr    = ptr[ADDR_W-1:0];
          ptr_next = ptr + 1'b1;
        end
      end
      S_COPY: begin
        if (ptr < fill) begin
          iss      = 1'b1;
          raddr    = ptr[ADDR_W-1:0];
          ptr_next = ptr + 1'b1;
        end
        if (tag_vld) begin
          we    = 1'b1;
          waddr = tag - k;
          wdata = rdata;
        end
        if (ptr >= fill && !tag_vld) begin
          fill_next  = fill - CNT_W'(k);
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        if (ptr < CNT_W'(FRAME_LEN)) begin
          iss      = 1'b1;
          raddr    = ptr[ADDR_W-1:0];
          ptr_next = ptr + 1'b1;
        end else if (!tag_vld) begin
          if (match) begin
            state_next = S_EMIT;
          end else begin
            ptr_next   = CNT_W'(POS_SYNC_B);
            state_next = S_SCAN;
          end
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          emit       = 1'b1;
          fill_next  = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign sum_ctl.clr = clr;
  assign sum_ctl.vld = tag_vld && (state == S_SUM);
  assign sum_ctl.tag = tag;

  `SFDF_ASSERT_NXT(a_accept_fill, in_ready && in_valid, state == S_HDR0 && fill == $past(fill) + 1'b1, "accepted beat did not advance fill")
  `SFDF_ASSERT_NXT(a_emit_clear, emit, state == S_IDLE && fill == '0, "store not cleared after emit")
  `SFDF_ASSERT_IMP(a_ready_room, in_ready, fill < CNT_W'(FRAME_LEN), "ready with a full store")
  `SFDF_ASSERT_IMP(a_copy_down, state == S_COPY && we, waddr < tag, "resync copy not moving down")

endmodule
